// ===== hdl/pcf_pkg.sv =====
// shared constants, register codes and stage bundles of the pitch complementary filter
// no dependencies; imported by every module of the block
package pcf_pkg;

  localparam int ADC_BITS_DEF = 10;
  localparam int REG_ADDR_W   = 5;
  localparam int G_Q8         = 2511;    // 9.81 m/s^2 in q8.8
  localparam int RAD_Q8       = 14669;   // 57.3 deg/rad in q8.8
  localparam int RATE_K       = 25600;   // 100 * 256
  localparam int ANGLE_MAX    = 46080;
  localparam int RATE_MAX     = 524287;
  localparam int WEIGHT_ONE   = 65536;
  localparam int RATE_W       = 20;
  localparam int ANGLE_W      = 17;
  localparam int WHEEL_W      = 13;
  localparam int GSCALE_W     = 13;
  localparam int PERIOD_W     = 10;
  localparam int WEIGHT_W     = 17;
  localparam int DEN_SW       = 14;      // signed tilt divisor, q8.8
  localparam int DEN_W        = 21;      // tilt divisor magnitude, q.16
  localparam int TILT_W       = 39;      // clamped tilt, signed
  localparam int TILT_MAG_W   = 38;
  localparam longint TILT_LIM = 64'sd1 <<< 37;  // far enough out to force saturation
  localparam int GANG_W       = 21;
  localparam int RM_W         = 30;      // |rate| * period
  localparam int RECIP_W      = 31;
  localparam logic [RECIP_W-1:0] RECIP_1000 = 31'd1099511628;  // ceil(2^40 / 1000)
  localparam int RECIP_SHIFT  = 40;

  typedef enum logic [2:0] {
    REG_X_OFS   = 3'd0,
    REG_X_SCALE = 3'd1,
    REG_Z_OFS   = 3'd2,
    REG_Z_SCALE = 3'd3,
    REG_G_OFS   = 3'd4,
    REG_G_SCALE = 3'd5,
    REG_PERIOD  = 3'd6,
    REG_WEIGHT  = 3'd7
  } reg_idx_e;

  // travels alongside the scaling dividers
  typedef struct packed {
    logic signed [WHEEL_W-1:0] wheel;
    logic signed [ANGLE_W-1:0] prev;
    logic                      fault_x;
    logic                      fault_z;
    logic                      fault_g;
    logic                      neg_x;
  } pcf_front_t;

  // travels alongside the tilt divider
  typedef struct packed {
    logic signed [RATE_W-1:0]  rate;
    logic signed [ANGLE_W-1:0] prev;
    logic [RATE_W-1:0]         gyro_step;
    logic                      step_neg;
    logic                      fault;
    logic                      den_zero;
    logic                      num_neg;
    logic                      tilt_neg;
  } pcf_side_t;

endpackage

// ===== hdl/pcf_regs.sv =====
// apb calibration register file of the pitch complementary filter
// depends on pcf_pkg for register codes and widths
module pcf_regs import pcf_pkg::*; #(
  parameter int ADC_BITS = ADC_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [REG_ADDR_W-1:0]      paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output logic [ADC_BITS-1:0]        x_ofs_o,
  output logic [ADC_BITS-1:0]        x_scale_o,
  output logic [ADC_BITS-1:0]        z_ofs_o,
  output logic [ADC_BITS-1:0]        z_scale_o,
  output logic [ADC_BITS-1:0]        g_ofs_o,
  output logic signed [GSCALE_W-1:0] g_scale_o,
  output logic [PERIOD_W-1:0]        period_o,
  output logic [WEIGHT_W-1:0]        weight_o
);

  localparam logic [ADC_BITS-1:0] OFS_RST   = ADC_BITS'(1 << (ADC_BITS - 1));
  localparam logic [ADC_BITS-1:0] SCALE_RST = ADC_BITS'(200);

  logic [ADC_BITS-1:0] x_ofs_q, x_scale_q, z_ofs_q, z_scale_q, g_ofs_q;
  logic [GSCALE_W-1:0] g_scale_q;
  logic [PERIOD_W-1:0] period_q;
  logic [WEIGHT_W-1:0] weight_q;
  logic                wr;
  reg_idx_e            idx;

  assign wr     = psel & penable & pwrite;
  assign idx    = reg_idx_e'(paddr[REG_ADDR_W-1:2]);
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_ofs_q   <= OFS_RST;
      x_scale_q <= SCALE_RST;
      z_ofs_q   <= OFS_RST;
      z_scale_q <= SCALE_RST;
      g_ofs_q   <= OFS_RST;
      g_scale_q <= GSCALE_W'(1);
      period_q  <= PERIOD_W'(10);
      weight_q  <= WEIGHT_W'(64225);
    end else if (wr) begin
      case (idx)
        REG_X_OFS:   x_ofs_q   <= pwdata[ADC_BITS-1:0];
        REG_X_SCALE: x_scale_q <= pwdata[ADC_BITS-1:0];
        REG_Z_OFS:   z_ofs_q   <= pwdata[ADC_BITS-1:0];
        REG_Z_SCALE: z_scale_q <= pwdata[ADC_BITS-1:0];
        REG_G_OFS:   g_ofs_q   <= pwdata[ADC_BITS-1:0];
        REG_G_SCALE: g_scale_q <= pwdata[GSCALE_W-1:0];
        REG_PERIOD:  period_q  <= pwdata[PERIOD_W-1:0];
        REG_WEIGHT:  weight_q  <= pwdata[WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_X_OFS:   prdata = 32'(x_ofs_q);
      REG_X_SCALE: prdata = 32'(x_scale_q);
      REG_Z_OFS:   prdata = 32'(z_ofs_q);
      REG_Z_SCALE: prdata = 32'(z_scale_q);
      REG_G_OFS:   prdata = 32'(g_ofs_q);
      REG_G_SCALE: prdata = 32'(g_scale_q);
      REG_PERIOD:  prdata = 32'(period_q);
      REG_WEIGHT:  prdata = 32'(weight_q);
      default:     prdata = '0;
    endcase
  end

  assign x_ofs_o   = x_ofs_q;
  assign x_scale_o = x_scale_q;
  assign z_ofs_o   = z_ofs_q;
  assign z_scale_o = z_scale_q;
  assign g_ofs_o   = g_ofs_q;
  assign g_scale_o = $signed(g_scale_q);
  assign period_o  = period_q;
  assign weight_o  = weight_q;

endmodule

// ===== hdl/pcf_div.sv =====
// pipelined unsigned restoring divider, one quotient bit per stage, with sideband
// depends on pcf_pkg only by convention; the stages advance only while en_i is high
module pcf_div import pcf_pkg::*; #(
  parameter int DVD_W  = 30,
  parameter int DVS_W  = 13,
  parameter int SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [DVD_W-1:0]  dividend_i,
  input  logic [DVS_W-1:0]  divisor_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [DVD_W-1:0]  quotient_o,
  output logic [SIDE_W-1:0] side_o
);

  logic              vld_q  [DVD_W];
  logic [DVS_W-1:0]  rem_q  [DVD_W];
  logic [DVD_W-1:0]  wq_q   [DVD_W];
  logic [DVS_W-1:0]  dvs_q  [DVD_W];
  logic [SIDE_W-1:0] side_q [DVD_W];

  for (genvar s = 0; s < DVD_W; s++) begin : g_stage
    logic              vld_in;
    logic [DVS_W-1:0]  rem_in;
    logic [DVD_W-1:0]  wq_in;
    logic [DVS_W-1:0]  dvs_in;
    logic [SIDE_W-1:0] side_in;
    logic [DVS_W:0]    trial;
    logic [DVS_W:0]    diff;
    logic              take;

    if (s == 0) begin : g_first
      assign vld_in  = valid_i;
      assign rem_in  = '0;
      assign wq_in   = dividend_i;
      assign dvs_in  = divisor_i;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign wq_in   = wq_q[s-1];
      assign dvs_in  = dvs_q[s-1];
      assign side_in = side_q[s-1];
    end

    // shift in the next dividend bit, subtract when it fits
    assign trial = {rem_in, wq_in[DVD_W-1]};
    assign diff  = trial - {1'b0, dvs_in};
    assign take  = trial >= {1'b0, dvs_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= take ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        wq_q[s]   <= {wq_in[DVD_W-2:0], take};
        dvs_q[s]  <= dvs_in;
        side_q[s] <= side_in;
      end
    end
  end

  assign valid_o    = vld_q[DVD_W-1];
  assign quotient_o = wq_q[DVD_W-1];
  assign side_o     = side_q[DVD_W-1];

endmodule

// ===== hdl/pcf_blend.sv =====
// back end of the pitch filter: tilt and gyro angle, weighted blend, saturation
// depends on pcf_pkg for the sideband struct and constants; three register stages
module pcf_blend import pcf_pkg::*; #(
  parameter int Q_W = 46
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [Q_W-1:0]            quot_i,
  input  pcf_side_t                 side_i,
  input  logic [WEIGHT_W-1:0]       weight_i,
  output logic                      valid_o,
  output logic signed [ANGLE_W-1:0] pitch_angle_o,
  output logic signed [RATE_W-1:0]  pitch_rate_o,
  output logic                      div_fault_o
);

  localparam int PT_W  = WEIGHT_W + 1 + TILT_W;
  localparam int PG_W  = WEIGHT_W + 1 + GANG_W;
  localparam int SUM_W = PT_W + 1;
  localparam int ANG_W = SUM_W - 16;

  logic [TILT_MAG_W-1:0]     mag;
  logic signed [TILT_W-1:0]  tilt_d, tilt_q;
  logic signed [GANG_W-1:0]  step, gang_d, gang_q;
  logic [WEIGHT_W-1:0]       wc, wi;
  logic signed [PT_W-1:0]    pt_d, pt_q;
  logic signed [PG_W-1:0]    pg_d, pg_q;
  logic signed [SUM_W-1:0]   sum;
  logic signed [ANG_W-1:0]   ang;
  logic signed [RATE_W-1:0]  rate_f_q, rate_g_q;
  logic                      fault_f_q, fault_g_q;
  logic                      vld_f_q, vld_g_q, vld_o_q;
  logic signed [ANGLE_W-1:0] angle_q;
  logic signed [RATE_W-1:0]  rate_o_q;
  logic                      fault_o_q;
  logic                      sat_hi, sat_lo;

  // stage f: signed tilt, clamped; gyro angle
  always_comb begin
    mag = (quot_i > Q_W'(TILT_LIM)) ? TILT_MAG_W'(TILT_LIM) : quot_i[TILT_MAG_W-1:0];
    if (side_i.den_zero) begin
      tilt_d = side_i.num_neg ? -TILT_W'(ANGLE_MAX) : TILT_W'(ANGLE_MAX);
    end else begin
      tilt_d = side_i.tilt_neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end
    step   = side_i.step_neg ? -$signed({1'b0, side_i.gyro_step})
                             : $signed({1'b0, side_i.gyro_step});
    gang_d = step + GANG_W'(side_i.prev);
  end

  // weight above one counts as one
  assign wc = (weight_i > WEIGHT_W'(WEIGHT_ONE)) ? WEIGHT_W'(WEIGHT_ONE) : weight_i;
  assign wi = WEIGHT_W'(WEIGHT_ONE) - wc;

  // stage g: weighted products
  assign pt_d = PT_W'($signed({1'b0, wc})) * PT_W'(tilt_q);
  assign pg_d = PG_W'($signed({1'b0, wi})) * PG_W'(gang_q);

  // stage out: round, floor shift, saturate
  assign sum    = SUM_W'(pt_q) + SUM_W'(pg_q) + SUM_W'(32768);
  assign ang    = sum[SUM_W-1:16];
  assign sat_hi = ang > ANG_W'(ANGLE_MAX);
  assign sat_lo = ang < -ANG_W'(ANGLE_MAX);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_f_q <= 1'b0;
      vld_g_q <= 1'b0;
      vld_o_q <= 1'b0;
    end else if (en_i) begin
      vld_f_q <= valid_i;
      vld_g_q <= vld_f_q;
      vld_o_q <= vld_g_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tilt_q    <= tilt_d;
      gang_q    <= gang_d;
      rate_f_q  <= side_i.rate;
      fault_f_q <= side_i.fault | side_i.den_zero;
      pt_q      <= pt_d;
      pg_q      <= pg_d;
      rate_g_q  <= rate_f_q;
      fault_g_q <= fault_f_q;
      angle_q   <= sat_hi ? ANGLE_W'(ANGLE_MAX) :
                   sat_lo ? -ANGLE_W'(ANGLE_MAX) : ang[ANGLE_W-1:0];
      rate_o_q  <= rate_g_q;
      fault_o_q <= fault_g_q | sat_hi | sat_lo;
    end
  end

  assign valid_o       = vld_o_q;
  assign pitch_angle_o = angle_q;
  assign pitch_rate_o  = rate_o_q;
  assign div_fault_o   = fault_o_q;

endmodule

// ===== hdl/pitch_complementary_filter.sv =====
// top level of the pitch complementary filter: front end, dividers, blend
// depends on pcf_pkg, pcf_regs, pcf_div and pcf_blend
//
// pitch estimator for a balancing platform. each input beat carries raw
// accelerometer x/z samples, a raw gyro sample, the wheel acceleration (q8.8
// m/s^2) and the previous pitch angle (q.8 degrees); each gives exactly one
// output beat with the blended pitch angle (q.8 deg, saturated to +-180),
// the gyro rate (q.8 deg/s, saturated to 20 bits) and a fault flag that is
// set when a calibration divisor or the tilt divisor (9.81 - wheel accel) is
// zero or a result saturated. the calibration registers sit on an apb port
// at byte addresses 4*i and may only change while no beat is in flight.
// the datapath is a single stall-together pipeline: one beat enters every
// clock while in_stall_o is low; the two bit-serial divider pipelines take
// one quotient bit per stage (ADC_BITS+20 stages for the calibration
// scaling, ADC_BITS+36 for the tilt). out_stall_i freezes every stage, so
// in_stall_o follows it while the output register holds a beat.
module pitch_complementary_filter import pcf_pkg::*; #(
  parameter int ADC_BITS = ADC_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // input beats
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [ADC_BITS-1:0]       accel_x_raw_i,
  input  logic [ADC_BITS-1:0]       accel_z_raw_i,
  input  logic [ADC_BITS-1:0]       gyro_raw_i,
  input  logic signed [WHEEL_W-1:0] wheel_accel_i,
  input  logic signed [ANGLE_W-1:0] prev_angle_i,
  // output beats
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [ANGLE_W-1:0] pitch_angle_o,
  output logic signed [RATE_W-1:0]  pitch_rate_o,
  output logic                      div_fault_o,
  // calibration registers
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [REG_ADDR_W-1:0]     paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  // scaled acceleration magnitude: |raw - offset| * 9.81 * 65536
  localparam int ACC_W = ADC_BITS + 20;
  localparam int DVS_W = (ADC_BITS > GSCALE_W) ? ADC_BITS : GSCALE_W;
  // tilt numerator, signed q.16, and its product with 57.3
  localparam int NUM_W = ACC_W + 3;
  localparam int P_W   = NUM_W - 1 + 14;

  logic                      en;

  logic [ADC_BITS-1:0]       x_ofs, x_scale, z_ofs, z_scale, g_ofs;
  logic signed [GSCALE_W-1:0] g_scale;
  logic [PERIOD_W-1:0]       period;
  logic [WEIGHT_W-1:0]       weight;

  // stage a: offset removal and gain products
  logic signed [ADC_BITS:0]  dx, dz, dg;
  logic [ADC_BITS-1:0]       adx, adz, adg;
  logic [GSCALE_W-1:0]       ags;
  pcf_front_t                front_d, front_q;
  logic [ACC_W-1:0]          mx_q, mz_q, mg_q;
  logic [DVS_W-1:0]          dvx_q, dvz_q, dvg_q;
  logic                      negz_q, negg_q, vld_a_q;

  // scaling dividers
  logic                      vx, vz, vg;
  logic [ACC_W-1:0]          qx, qz, qg;
  pcf_front_t                front_b;
  logic                      negz_b, negg_b;

  // stage c: numerator, divisor, rate
  logic signed [ACC_W:0]     accx, accz;
  logic signed [NUM_W-1:0]   num_d, num_q;
  logic signed [DEN_SW-1:0]  den_d, den_q;
  logic                      rsat_hi, rsat_lo;
  logic signed [RATE_W-1:0]  rate_d, rate_c_q;
  logic signed [ANGLE_W-1:0] prev_c_q;
  logic                      fault_c_q, vld_c_q;

  // stage d: tilt operands, gyro step product
  logic                      num_neg;
  logic signed [NUM_W-1:0]   anum;
  logic [DEN_SW-2:0]         aden;
  logic [RATE_W-1:0]         arate;
  logic [P_W-1:0]            pmag_d_q;
  logic [DEN_W-1:0]          dmag_d_q;
  logic [RM_W-1:0]           rm_q;
  logic                      dz_q, numneg_q, tneg_q, rneg_q;
  logic signed [RATE_W-1:0]  rate_d_q;
  logic signed [ANGLE_W-1:0] prev_d_q;
  logic                      fault_d_q, vld_d_q;

  // stage e: divide the gyro step by 1000 through the reciprocal
  logic [RM_W+RECIP_W-1:0]   gp;
  pcf_side_t                 side_d, side_q;
  logic [P_W-1:0]            pmag_e_q;
  logic [DEN_W-1:0]          dmag_e_q;
  logic                      vld_e_q;

  // tilt divider
  logic                      vt;
  logic [P_W-1:0]            qt;
  pcf_side_t                 side_t;

  // the whole pipe moves unless a finished beat is held at the output
  assign en         = !out_valid_o || !out_stall_i;
  assign in_stall_o = !en;

  pcf_regs #(.ADC_BITS(ADC_BITS)) u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .x_ofs_o   (x_ofs),
    .x_scale_o (x_scale),
    .z_ofs_o   (z_ofs),
    .z_scale_o (z_scale),
    .g_ofs_o   (g_ofs),
    .g_scale_o (g_scale),
    .period_o  (period),
    .weight_o  (weight)
  );

  // ---------------- stage a ----------------
  // sign and magnitude of each offset-corrected sample; the gyro is inverted
  always_comb begin
    dx  = $signed({1'b0, accel_x_raw_i}) - $signed({1'b0, x_ofs});
    dz  = $signed({1'b0, accel_z_raw_i}) - $signed({1'b0, z_ofs});
    dg  = $signed({1'b0, g_ofs}) - $signed({1'b0, gyro_raw_i});
    adx = dx[ADC_BITS] ? ADC_BITS'(-dx) : ADC_BITS'(dx);
    adz = dz[ADC_BITS] ? ADC_BITS'(-dz) : ADC_BITS'(dz);
    adg = dg[ADC_BITS] ? ADC_BITS'(-dg) : ADC_BITS'(dg);
    ags = g_scale[GSCALE_W-1] ? GSCALE_W'(-g_scale) : GSCALE_W'(g_scale);

    front_d.wheel   = wheel_accel_i;
    front_d.prev    = prev_angle_i;
    front_d.fault_x = (x_scale == '0);
    front_d.fault_z = (z_scale == '0);
    front_d.fault_g = (g_scale == '0);
    front_d.neg_x   = dx[ADC_BITS];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
    end else if (en) begin
      vld_a_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mx_q    <= ACC_W'(adx) * ACC_W'(G_Q8 * 256);
      mz_q    <= ACC_W'(adz) * ACC_W'(G_Q8 * 256);
      mg_q    <= ACC_W'(adg) * ACC_W'(RATE_K);
      dvx_q   <= DVS_W'(x_scale);
      dvz_q   <= DVS_W'(z_scale);
      dvg_q   <= DVS_W'(ags);
      front_q <= front_d;
      negz_q  <= dz[ADC_BITS];
      negg_q  <= dg[ADC_BITS] ^ g_scale[GSCALE_W-1];
    end
  end

  // ---------------- scaling dividers ----------------
  pcf_div #(.DVD_W(ACC_W), .DVS_W(DVS_W), .SIDE_W($bits(pcf_front_t))) u_div_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (vld_a_q),
    .dividend_i (mx_q),
    .divisor_i  (dvx_q),
    .side_i     (front_q),
    .valid_o    (vx),
    .quotient_o (qx),
    .side_o     (front_b)
  );

  pcf_div #(.DVD_W(ACC_W), .DVS_W(DVS_W), .SIDE_W(1)) u_div_z (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (vld_a_q),
    .dividend_i (mz_q),
    .divisor_i  (dvz_q),
    .side_i     (negz_q),
    .valid_o    (vz),
    .quotient_o (qz),
    .side_o     (negz_b)
  );

  pcf_div #(.DVD_W(ACC_W), .DVS_W(DVS_W), .SIDE_W(1)) u_div_g (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (vld_a_q),
    .dividend_i (mg_q),
    .divisor_i  (dvg_q),
    .side_i     (negg_q),
    .valid_o    (vg),
    .quotient_o (qg),
    .side_o     (negg_b)
  );

  // ---------------- stage c ----------------
  always_comb begin
    // a zero gain drops that term
    if (front_b.fault_x) begin
      accx = '0;
    end else begin
      accx = front_b.neg_x ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
    end
    // z axis enters with inverted sign
    if (front_b.fault_z) begin
      accz = '0;
    end else begin
      accz = negz_b ? $signed({1'b0, qz}) : -$signed({1'b0, qz});
    end
    num_d = NUM_W'(accx) + NUM_W'(accz) - (NUM_W'(front_b.wheel) <<< 8)
            - NUM_W'(G_Q8 * 256);
    den_d = DEN_SW'(G_Q8) - DEN_SW'(front_b.wheel);

    rsat_hi = !front_b.fault_g && !negg_b && (qg > ACC_W'(RATE_MAX));
    rsat_lo = !front_b.fault_g && negg_b && (qg > ACC_W'(RATE_MAX + 1));
    if (front_b.fault_g) begin
      rate_d = '0;
    end else if (rsat_hi) begin
      rate_d = RATE_W'(RATE_MAX);
    end else if (rsat_lo) begin
      rate_d = -RATE_W'(RATE_MAX + 1);
    end else begin
      rate_d = negg_b ? -RATE_W'(qg) : RATE_W'(qg);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_c_q <= 1'b0;
    end else if (en) begin
      vld_c_q <= vx & vz & vg;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      num_q     <= num_d;
      den_q     <= den_d;
      rate_c_q  <= rate_d;
      prev_c_q  <= front_b.prev;
      fault_c_q <= front_b.fault_x | front_b.fault_z | front_b.fault_g | rsat_hi | rsat_lo;
    end
  end

  // ---------------- stage d ----------------
  always_comb begin
    num_neg = num_q[NUM_W-1];
    anum    = num_neg ? -num_q : num_q;
    aden    = den_q[DEN_SW-1] ? (DEN_SW-1)'(-den_q) : (DEN_SW-1)'(den_q);
    arate   = rate_c_q[RATE_W-1] ? RATE_W'(-rate_c_q) : RATE_W'(rate_c_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_d_q <= 1'b0;
    end else if (en) begin
      vld_d_q <= vld_c_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pmag_d_q  <= P_W'(anum[NUM_W-2:0]) * P_W'(RAD_Q8);
      dmag_d_q  <= {aden, 8'h00};
      dz_q      <= (den_q == '0);
      numneg_q  <= num_neg;
      tneg_q    <= num_neg ^ den_q[DEN_SW-1];
      rm_q      <= RM_W'(arate) * RM_W'(period);
      rneg_q    <= rate_c_q[RATE_W-1];
      rate_d_q  <= rate_c_q;
      prev_d_q  <= prev_c_q;
      fault_d_q <= fault_c_q;
    end
  end

  // ---------------- stage e ----------------
  assign gp = (RM_W+RECIP_W)'(rm_q) * (RM_W+RECIP_W)'(RECIP_1000);

  always_comb begin
    side_d.rate      = rate_d_q;
    side_d.prev      = prev_d_q;
    side_d.gyro_step = gp[RECIP_SHIFT+RATE_W-1:RECIP_SHIFT];
    side_d.step_neg  = rneg_q;
    side_d.fault     = fault_d_q;
    side_d.den_zero  = dz_q;
    side_d.num_neg   = numneg_q;
    side_d.tilt_neg  = tneg_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_e_q <= 1'b0;
    end else if (en) begin
      vld_e_q <= vld_d_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pmag_e_q <= pmag_d_q;
      dmag_e_q <= dmag_d_q;
      side_q   <= side_d;
    end
  end

  // ---------------- tilt divider ----------------
  pcf_div #(.DVD_W(P_W), .DVS_W(DEN_W), .SIDE_W($bits(pcf_side_t))) u_div_tilt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (vld_e_q),
    .dividend_i (pmag_e_q),
    .divisor_i  (dmag_e_q),
    .side_i     (side_q),
    .valid_o    (vt),
    .quotient_o (qt),
    .side_o     (side_t)
  );

  // ---------------- blend and output register ----------------
  pcf_blend #(.Q_W(P_W)) u_blend (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .valid_i       (vt),
    .quot_i        (qt),
    .side_i        (side_t),
    .weight_i      (weight),
    .valid_o       (out_valid_o),
    .pitch_angle_o (pitch_angle_o),
    .pitch_rate_o  (pitch_rate_o),
    .div_fault_o   (div_fault_o)
  );

endmodule

// ===== tb/tb.sv =====
// self-checking testbench of pitch_complementary_filter
// depends on pcf_pkg and the rtl of the block; random output stalls and input gaps
`timescale 1ns / 1ps

module tb import pcf_pkg::*;;

  // expected output beat
  typedef struct {
    logic signed [ANGLE_W-1:0] angle;
    logic signed [RATE_W-1:0]  rate;
    logic                      fault;
  } pitch_res_t;

  // calibration copy and queue of pending pitch results
  class pitch_board;
    longint unsigned cal [8];
    pitch_res_t pending [$];
    int errors;

    function new();
      cal[REG_X_OFS] = 512; cal[REG_X_SCALE] = 200;
      cal[REG_Z_OFS] = 512; cal[REG_Z_SCALE] = 200;
      cal[REG_G_OFS] = 512; cal[REG_G_SCALE] = 1;
      cal[REG_PERIOD] = 10; cal[REG_WEIGHT] = 64225;
      errors = 0;
    endfunction

    function void set_cal(reg_idx_e idx, longint unsigned v);
      case (idx)
        REG_G_SCALE: cal[idx] = v & 13'h1fff;
        REG_PERIOD:  cal[idx] = v & 10'h3ff;
        REG_WEIGHT:  cal[idx] = v & 17'h1ffff;
        default:     cal[idx] = v & 10'h3ff;
      endcase
    endfunction

    // work out the pitch result of one accepted input beat
    function void note_sample(longint ax, longint az, longint gr,
                              logic signed [WHEEL_W-1:0] wh,
                              logic signed [ANGLE_W-1:0] pv);
      longint xpp, prev, gs, w, accx, accz, num, den, tilt, rate, gang, sum, ang;
      logic signed [GSCALE_W-1:0] gs_s;
      bit f;
      pitch_res_t r;
      f = 0; accx = 0; accz = 0; rate = 0;
      xpp = wh; prev = pv;
      gs_s = GSCALE_W'(cal[REG_G_SCALE]); gs = gs_s;
      w = cal[REG_WEIGHT];
      if (cal[REG_X_SCALE] != 0)
        accx = ((ax - longint'(cal[REG_X_OFS])) * G_Q8 * 256) / longint'(cal[REG_X_SCALE]);
      else f = 1;
      if (cal[REG_Z_SCALE] != 0)
        accz = -(((az - longint'(cal[REG_Z_OFS])) * G_Q8 * 256) / longint'(cal[REG_Z_SCALE]));
      else f = 1;
      num = accx + accz - xpp * 256 - longint'(G_Q8) * 256;
      den = G_Q8 - xpp;
      if (den != 0) tilt = (num * RAD_Q8) / (den * 256);
      else begin
        tilt = (num >= 0) ? ANGLE_MAX : -ANGLE_MAX;
        f = 1;
      end
      if (gs != 0) rate = (-(gr - longint'(cal[REG_G_OFS])) * 25600) / gs;
      else f = 1;
      if (rate > RATE_MAX) begin rate = RATE_MAX; f = 1; end
      if (rate < -RATE_MAX - 1) begin rate = -RATE_MAX - 1; f = 1; end
      gang = (rate * longint'(cal[REG_PERIOD])) / 1000 + prev;
      if (w > WEIGHT_ONE) w = WEIGHT_ONE;
      sum = w * tilt + (WEIGHT_ONE - w) * gang + 32768;
      ang = sum / WEIGHT_ONE;
      if (sum % WEIGHT_ONE != 0 && sum < 0) ang -= 1;
      if (ang > ANGLE_MAX) begin ang = ANGLE_MAX; f = 1; end
      if (ang < -ANGLE_MAX) begin ang = -ANGLE_MAX; f = 1; end
      r.angle = ANGLE_W'(ang); r.rate = RATE_W'(rate); r.fault = f;
      pending.push_back(r);
    endfunction

    function void report_mismatch(string msg);
      errors++;
      $display("mismatch at %0t: %s", $time, msg);
    endfunction

    function void check_beat(logic signed [ANGLE_W-1:0] a,
                             logic signed [RATE_W-1:0] rt, logic fl);
      pitch_res_t e;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected output beat angle %0d", a));
        return;
      end
      e = pending.pop_front();
      if (a !== e.angle)
        report_mismatch($sformatf("pitch_angle %0d, want %0d", a, e.angle));
      if (rt !== e.rate)
        report_mismatch($sformatf("pitch_rate %0d, want %0d", rt, e.rate));
      if (fl !== e.fault)
        report_mismatch($sformatf("div_fault %0b, want %0b", fl, e.fault));
    endfunction
  endclass

  localparam int LATENCY  = 2 * ADC_BITS_DEF + 63;
  localparam int WD_LIMIT = 20000;

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o, out_valid_o, out_stall_i;
  logic [9:0] accel_x_raw_i, accel_z_raw_i, gyro_raw_i;
  logic signed [WHEEL_W-1:0] wheel_accel_i;
  logic signed [ANGLE_W-1:0] prev_angle_i;
  logic signed [ANGLE_W-1:0] pitch_angle_o;
  logic signed [RATE_W-1:0]  pitch_rate_o;
  logic div_fault_o;
  logic psel, penable, pwrite, pready;
  logic [REG_ADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;

  pitch_board sb;
  bit quiet_tail;   // no idling in the last part of the run
  int idle_cnt;
  int stall_left;
  int watchdog;

  pitch_complementary_filter dut (.*);

  initial begin
    clk_i = 0;
    forever #2 clk_i = ~clk_i;
  end

  // check each output beat, accepted when valid and not stalled
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_beat(pitch_angle_o, pitch_rate_o, div_fault_o);
  end

  // receiver stalls in random bursts
  always @(posedge clk_i) begin
    if (!rst_ni || quiet_tail) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if ($urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 10);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // watchdog on cycles with no accepted beat and no apb access
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)
        || (psel && penable))
      watchdog = 0;
    else if (++watchdog >= WD_LIMIT) begin
      $display("watchdog timeout");
      $display("end of test: mismatches");
      $finish;
    end
  end

  // apb write (setup then access phase), block idle
  task automatic write_cal(reg_idx_e idx, longint unsigned v);
    @(posedge clk_i);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= REG_ADDR_W'(4 * int'(idx)); pwdata <= 32'(v);
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    sb.set_cal(idx, v);
  endtask

  // send one input beat, with a random idle burst ahead of it
  task automatic send_sample(int ax, int az, int gr, int wh, int pv);
    if (!quiet_tail && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    in_valid_i <= 1;
    accel_x_raw_i <= 10'(ax); accel_z_raw_i <= 10'(az); gyro_raw_i <= 10'(gr);
    wheel_accel_i <= WHEEL_W'(wh); prev_angle_i <= ANGLE_W'(pv);
    do @(posedge clk_i); while (in_stall_o);
    sb.note_sample(ax, az, gr, WHEEL_W'(wh), ANGLE_W'(pv));
  endtask

  // random beat: mostly plausible tilt, sometimes any value
  task automatic send_random();
    int wh;
    case ($urandom_range(0, 9))
      0: wh = G_Q8;
      1, 2: wh = $urandom_range(0, 8191) - 4096;
      default: wh = $urandom_range(0, 1024) - 512;
    endcase
    send_sample($urandom_range(0, 1023), $urandom_range(0, 1023),
                $urandom_range(0, 1023), wh,
                ($urandom_range(0, 3) == 0) ? $urandom_range(0, 131071) - 65536
                                            : $urandom_range(0, 92160) - 46080);
  endtask

  // let the pipe drain before a register write
  task automatic drain();
    in_valid_i <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 5) @(posedge clk_i);
  endtask

  initial begin
    sb = new();
    quiet_tail = 0; watchdog = 0;
    rst_ni = 0; in_valid_i = 0;
    accel_x_raw_i = 0; accel_z_raw_i = 0; gyro_raw_i = 0;
    wheel_accel_i = 0; prev_angle_i = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: field extremes and the divisor cases at reset calibration
    send_sample(0, 0, 0, -4096, -46080);
    send_sample(1023, 1023, 1023, 4095, 46080);
    send_sample(512, 512, 512, 0, 0);
    send_sample(712, 512, 512, G_Q8, 0);          // zero tilt divisor, num < 0
    send_sample(0, 1023, 512, G_Q8, 0);           // zero tilt divisor, num < 0
    send_sample(1023, 0, 0, 0, 65535);            // prev beyond range
    send_sample(0, 1023, 1023, 0, -65536);
    send_sample(300, 700, 100, -1, 12345);
    drain();
    // zero scales, large rate -> saturation, weight above one
    write_cal(REG_X_SCALE, 0);
    write_cal(REG_Z_SCALE, 0);
    write_cal(REG_G_SCALE, 13'h1fff);             // -1 -> rate saturates
    write_cal(REG_WEIGHT, 17'h1ffff);
    write_cal(REG_PERIOD, 0);
    send_sample(0, 0, 0, 100, 100);
    send_sample(1023, 1023, 1023, -100, -100);
    send_sample(512, 512, 512, G_Q8, 0);
    drain();
    write_cal(REG_G_SCALE, 0);
    write_cal(REG_WEIGHT, 0);
    write_cal(REG_PERIOD, 1023);
    write_cal(REG_X_OFS, 1023);
    write_cal(REG_Z_OFS, 0);
    write_cal(REG_G_OFS, 1023);
    send_sample(0, 1023, 0, 0, 46080);
    send_sample(1023, 0, 1023, 0, -46080);
    drain();

    // random phases through several calibration settings
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          write_cal(REG_X_OFS, 512); write_cal(REG_X_SCALE, 200);
          write_cal(REG_Z_OFS, 512); write_cal(REG_Z_SCALE, 200);
          write_cal(REG_G_OFS, 512); write_cal(REG_G_SCALE, 1);
          write_cal(REG_PERIOD, 10); write_cal(REG_WEIGHT, 64225);
        end
        1: begin
          write_cal(REG_X_SCALE, 1); write_cal(REG_Z_SCALE, 1023);
          write_cal(REG_G_SCALE, 4095); write_cal(REG_PERIOD, 1000);
          write_cal(REG_WEIGHT, 65536);
        end
        2: begin
          write_cal(REG_X_SCALE, 1023); write_cal(REG_Z_SCALE, 1);
          write_cal(REG_G_SCALE, 13'h1000); write_cal(REG_PERIOD, 1);
          write_cal(REG_WEIGHT, 0); write_cal(REG_X_OFS, 0);
        end
        default: begin
          write_cal(REG_X_OFS, $urandom_range(0, 1023));
          write_cal(REG_X_SCALE, $urandom_range(1, 1023));
          write_cal(REG_Z_OFS, $urandom_range(0, 1023));
          write_cal(REG_Z_SCALE, $urandom_range(1, 1023));
          write_cal(REG_G_OFS, $urandom_range(0, 1023));
          write_cal(REG_G_SCALE, $urandom_range(1, 8191));
          write_cal(REG_PERIOD, $urandom_range(1, 1000));
          write_cal(REG_WEIGHT, $urandom_range(0, 65536));
        end
      endcase
      if (ph == 4) quiet_tail = 1;
      repeat (90) send_random();
      drain();
    end

    if (sb.errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
